### rtl/ipvrf_pkg.sv
`timescale 1ns / 1ps

package ipvrf_pkg;

	localparam int MAX_FRAME_BYTES = 2048;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int LEN_W           = 11;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	// room kept free so that a request in the input stage and one more can both land
	localparam int FIFO_ROOM  = 4;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ADDR      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_PROTOCOL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COPY_LIMIT      = 2'd2;

	localparam logic [LEN_W-1:0] COPY_LIMIT_RESET = 11'd1500;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [3:0] IP_VERSION      = 4'd4;
	localparam logic [3:0] IHL_MIN         = 4'd5;
	localparam logic [5:0] HDR_MIN_BYTES   = 6'd20;
	localparam int         OFS_TOTAL_HI    = 2;
	localparam int         OFS_TOTAL_LO    = 3;
	localparam int         OFS_PROTOCOL    = 9;
	localparam int         OFS_CHECKSUM_LO = 11;
	localparam int         OFS_SRC         = 12;
	localparam int         OFS_DST         = 16;
	localparam int         OFS_DST_END     = 20;

	typedef struct packed {
		logic [31:0]      local_addr;
		logic [7:0]       wanted_protocol;
		logic [LEN_W-1:0] copy_limit;
	} cfg_t;

	typedef struct packed {
		logic             result_kind;
		logic [7:0]       payload_byte;
		logic [31:0]      sender_addr;
		logic [LEN_W-1:0] copied_length;
		logic             truncated;
		logic             run_last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

### rtl/ipvrf_if.sv
`timescale 1ns / 1ps

interface ipvrf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface ipvrf_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [31:0] sender_addr;
	logic [10:0] copied_length;
	logic        truncated;
	logic        run_last;

	modport source (output valid, output result_kind, output payload_byte,
		output sender_addr, output copied_length, output truncated,
		output run_last, input ready);
	modport sink (input valid, input result_kind, input payload_byte,
		input sender_addr, input copied_length, input truncated,
		input run_last, output ready);
endinterface

interface ipvrf_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/ipvrf_parse.sv
`timescale 1ns / 1ps

module ipvrf_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       frame_byte,
	input  logic             frame_last,
	input  ipvrf_pkg::cfg_t  cfg,
	output ipvrf_pkg::push_t push
);
	import ipvrf_pkg::*;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic [POS_W-1:0] pos_q, pos_n;
	logic [5:0]       hl_q, hl_n;
	logic [15:0]      tl_q, tl_n;
	logic [15:0]      sum_q, sum_n;
	logic [7:0]       hold_q, hold_n;
	logic [15:0]      rcv_q, rcv_n;
	logic [31:0]      src_q, src_n;
	logic             rej_q, rej_n;
	logic [LEN_W-1:0] cnt_q, cnt_n;

	logic [POS_W-1:0] p;
	logic [15:0]      word;
	logic [16:0]      sum17;
	logic [7:0]       dst_byte;
	res_t             pay, summ;
	logic             pay_ok, summ_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= frame_byte;
			last_s1 <= frame_last;
		end
	end

	always_comb begin
		p        = pos_q;
		pos_n    = pos_q;
		hl_n     = hl_q;
		tl_n     = tl_q;
		sum_n    = sum_q;
		hold_n   = hold_q;
		rcv_n    = rcv_q;
		src_n    = src_q;
		rej_n    = rej_q;
		cnt_n    = cnt_q;
		word     = 16'd0;
		sum17    = 17'd0;
		dst_byte = 8'd0;
		pay_ok   = 1'b0;
		summ_ok  = 1'b0;
		pay      = '0;
		summ     = '0;

		if (32'(p) < MAX_FRAME_BYTES) begin
			pos_n = p + POS_W'(1);
			if (p == POS_W'(0)) begin
				if (byte_s1[7:4] != IP_VERSION || byte_s1[3:0] < IHL_MIN)
					rej_n = 1'b1;
				hl_n = {byte_s1[3:0], 2'b00};
			end
			if (32'(p) < 32'(hl_n)) begin
				if (p[0]) begin
					word = {hold_q, byte_s1};
					if (p == POS_W'(OFS_CHECKSUM_LO)) begin
						rcv_n = word;
						word  = 16'd0;
					end
					// end-around carry
					sum17 = {1'b0, sum_q} + {1'b0, word};
					if (sum17[16])
						sum_n = sum17[15:0] + 16'd1;
					else
						sum_n = sum17[15:0];
				end else begin
					hold_n = byte_s1;
				end
				if (p == POS_W'(OFS_TOTAL_HI) || p == POS_W'(OFS_TOTAL_LO))
					tl_n = {tl_q[7:0], byte_s1};
				if (p == POS_W'(OFS_PROTOCOL) && byte_s1 != cfg.wanted_protocol)
					rej_n = 1'b1;
				if (p >= POS_W'(OFS_SRC) && p < POS_W'(OFS_DST))
					src_n = {src_q[23:0], byte_s1};
				case (p[1:0])
					2'd0:    dst_byte = cfg.local_addr[31:24];
					2'd1:    dst_byte = cfg.local_addr[23:16];
					2'd2:    dst_byte = cfg.local_addr[15:8];
					default: dst_byte = cfg.local_addr[7:0];
				endcase
				if (p >= POS_W'(OFS_DST) && p < POS_W'(OFS_DST_END) && byte_s1 != dst_byte)
					rej_n = 1'b1;
				if (p[5:0] == hl_n - 6'd1) begin
					if (~sum_n != rcv_n)
						rej_n = 1'b1;
					if (tl_n <= {10'd0, hl_n})
						rej_n = 1'b1;
				end
			end else if (!rej_n && 32'(p) < 32'(tl_n) && cnt_q < cfg.copy_limit) begin
				pay_ok           = 1'b1;
				pay.result_kind  = KIND_PAYLOAD;
				pay.payload_byte = byte_s1;
				cnt_n            = cnt_q + LEN_W'(1);
			end
		end

		if (last_s1) begin
			if (!rej_n && hl_n >= HDR_MIN_BYTES && 32'(pos_n) >= 32'(hl_n)) begin
				summ_ok            = 1'b1;
				summ.result_kind   = KIND_SUMMARY;
				summ.sender_addr   = src_n;
				summ.copied_length = cnt_n;
				summ.truncated     = 32'(pos_n) < 32'(tl_n);
				summ.run_last      = 1'b1;
			end
			pos_n  = '0;
			hl_n   = '0;
			tl_n   = '0;
			sum_n  = '0;
			hold_n = '0;
			rcv_n  = '0;
			src_n  = '0;
			rej_n  = 1'b0;
			cnt_n  = '0;
		end
	end

	// compact: a lone summary goes in the first slot
	always_comb begin
		push = '0;
		if (valid_s1) begin
			if (pay_ok) begin
				push.r0  = pay;
				push.r1  = summ;
				push.cnt = summ_ok ? 2'd2 : 2'd1;
			end else if (summ_ok) begin
				push.r0  = summ;
				push.cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hl_q   <= '0;
			tl_q   <= '0;
			sum_q  <= '0;
			hold_q <= '0;
			rcv_q  <= '0;
			src_q  <= '0;
			rej_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (valid_s1) begin
			pos_q  <= pos_n;
			hl_q   <= hl_n;
			tl_q   <= tl_n;
			sum_q  <= sum_n;
			hold_q <= hold_n;
			rcv_q  <= rcv_n;
			src_q  <= src_n;
			rej_q  <= rej_n;
			cnt_q  <= cnt_n;
		end
	end

endmodule

### rtl/ipvrf_fifo.sv
`timescale 1ns / 1ps

module ipvrf_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ipvrf_pkg::push_t          push,
	input  logic                      pop,
	output logic [ipvrf_pkg::FIFO_CW-1:0] count,
	output ipvrf_pkg::res_t           head
);
	import ipvrf_pkg::*;

	res_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] count_q;
	logic               do_pop;

	assign do_pop = pop && count_q != '0;
	assign count  = count_q;
	assign head   = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem[wr_q] <= push.r0;
		if (push.cnt == 2'd2)
			mem[wr_q + FIFO_AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + FIFO_AW'(push.cnt);
			if (do_pop)
				rd_q <= rd_q + FIFO_AW'(1);
			count_q <= count_q + FIFO_CW'(push.cnt) - FIFO_CW'(do_pop);
		end
	end

endmodule

### rtl/ipv4_receive_filter.sv
`timescale 1ns / 1ps

// channel   dir  handshake      payload
// frame     in   valid/ready    frame_byte, frame_last
// result    out  valid/ready    result_kind, payload_byte, sender_addr,
//                               copied_length, truncated, run_last
// cfg       in   valid/ready    index (0 local_addr, 1 wanted_protocol, 2 copy_limit), data
//
// one frame byte per cycle while frame.ready is high; a byte is checked in the cycle
// after acceptance and its results sit in an 8-entry output queue from the edge after that
// frame.ready drops while more than four results wait; with result.ready held high
// the queue never fills that far, as only the frame end adds two results
// arst_n clears the frame state, the queue and the registers (copy_limit to 1500)
// cfg is always ready; writes land at once

module ipv4_receive_filter (
	input  logic        clk,
	input  logic        arst_n,
	ipvrf_in_if.sink    frame,
	ipvrf_out_if.source result,
	ipvrf_cfg_if.sink   cfg
);
	import ipvrf_pkg::*;

	cfg_t               cfg_q;
	push_t              push;
	res_t               head;
	logic [FIFO_CW-1:0] count;
	logic               take;

	assign frame.ready = 32'(count) <= FIFO_DEPTH - FIFO_ROOM;
	assign take        = frame.valid && frame.ready;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_addr      <= '0;
			cfg_q.wanted_protocol <= '0;
			cfg_q.copy_limit      <= COPY_LIMIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_LOCAL_ADDR:      cfg_q.local_addr      <= cfg.data;
				CFG_WANTED_PROTOCOL: cfg_q.wanted_protocol <= cfg.data[7:0];
				CFG_COPY_LIMIT:      cfg_q.copy_limit      <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	ipvrf_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.frame_byte (frame.frame_byte),
		.frame_last (frame.frame_last),
		.cfg        (cfg_q),
		.push       (push)
	);

	ipvrf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (result.ready),
		.count  (count),
		.head   (head)
	);

	assign result.valid         = count != '0;
	assign result.result_kind   = head.result_kind;
	assign result.payload_byte  = head.payload_byte;
	assign result.sender_addr   = head.sender_addr;
	assign result.copied_length = head.copied_length;
	assign result.truncated     = head.truncated;
	assign result.run_last      = head.run_last;

endmodule

### tb/sv/ipvrf_monitor.sv
`timescale 1ns / 1ps

module ipvrf_monitor (
	input  logic        clk,
	input  logic        arst_n,
	ipvrf_in_if         frame,
	ipvrf_out_if        result,
	ipvrf_cfg_if        cfg,
	output int unsigned due_left,
	output int unsigned mismatches,
	output int unsigned payload_seen,
	output int unsigned summary_seen
);
	import ipvrf_pkg::*;

	cfg_t             regs;
	logic [POS_W-1:0] pos;
	logic [5:0]       hdr_len;
	logic [15:0]      ip_len;
	logic [16:0]      csum_acc;
	logic [7:0]       hi_hold;
	logic [15:0]      csum_rx;
	logic [31:0]      sender_ip;
	logic             dropped;
	logic [LEN_W-1:0] n_copied;

	res_t        due_results[$];
	int unsigned bad_count;
	int unsigned n_payload;
	int unsigned n_summary;

	task automatic clear_packet();
		pos       = '0;
		hdr_len   = '0;
		ip_len    = '0;
		csum_acc  = '0;
		hi_hold   = '0;
		csum_rx   = '0;
		sender_ip = '0;
		dropped   = 1'b0;
		n_copied  = '0;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		case (idx)
			CFG_LOCAL_ADDR:      regs.local_addr = value;
			CFG_WANTED_PROTOCOL: regs.wanted_protocol = value[7:0];
			CFG_COPY_LIMIT:      regs.copy_limit = value[LEN_W-1:0];
			default: ;
		endcase
	endtask

	// one request of the frame channel: header checks, payload copy, summary at frame end
	task automatic filter_byte(input logic [7:0] b, input logic last);
		logic [POS_W-1:0] p;
		logic [15:0]      word;
		logic [16:0]      acc;
		int               sh;
		res_t             r;
		p = pos;
		if (p < MAX_FRAME_BYTES) begin
			pos = p + 1'b1;
			if (p == 0) begin
				if (b[7:4] != IP_VERSION || b[3:0] < IHL_MIN)
					dropped = 1'b1;
				hdr_len = {b[3:0], 2'b00};
			end
			if (p < hdr_len) begin
				if (p[0]) begin
					word = {hi_hold, b};
					if (p == OFS_CHECKSUM_LO) begin
						csum_rx = word;
						word    = '0;
					end
					acc = {1'b0, csum_acc[15:0]} + {1'b0, word};
					if (acc[16])
						acc = {1'b0, acc[15:0]} + 17'd1;
					csum_acc = acc;
				end else begin
					hi_hold = b;
				end
				if (p == OFS_TOTAL_HI || p == OFS_TOTAL_LO)
					ip_len = {ip_len[7:0], b};
				if (p == OFS_PROTOCOL && b != regs.wanted_protocol)
					dropped = 1'b1;
				if (p >= OFS_SRC && p < OFS_DST)
					sender_ip = {sender_ip[23:0], b};
				if (p >= OFS_DST && p < OFS_DST_END) begin
					// first destination byte meets the top byte of the own address
					sh = 8 * (OFS_DST_END - 1 - int'(p));
					if (b != regs.local_addr[sh +: 8])
						dropped = 1'b1;
				end
				if (p + 1'b1 == hdr_len) begin
					if (~csum_acc[15:0] != csum_rx)
						dropped = 1'b1;
					if (ip_len <= hdr_len)
						dropped = 1'b1;
				end
			end else if (!dropped && p < ip_len && n_copied < regs.copy_limit) begin
				r              = '0;
				r.result_kind  = KIND_PAYLOAD;
				r.payload_byte = b;
				due_results.push_back(r);
				n_copied++;
			end
		end
		if (last) begin
			if (!dropped && hdr_len >= HDR_MIN_BYTES && pos >= hdr_len) begin
				r               = '0;
				r.result_kind   = KIND_SUMMARY;
				r.sender_addr   = sender_ip;
				r.copied_length = n_copied;
				r.truncated     = pos < ip_len;
				r.run_last      = 1'b1;
				due_results.push_back(r);
			end
			clear_packet();
		end
	endtask

	function automatic int field_differs(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	task automatic compare_result();
		res_t want;
		int   wrong;
		if (due_results.size() == 0) begin
			$error("result request with nothing due: kind %0b byte %0h",
				result.result_kind, result.payload_byte);
			bad_count++;
		end else begin
			want  = due_results.pop_front();
			wrong = field_differs("result_kind", want.result_kind, result.result_kind)
				+ field_differs("payload_byte", want.payload_byte, result.payload_byte)
				+ field_differs("sender_addr", want.sender_addr, result.sender_addr)
				+ field_differs("copied_length", want.copied_length, result.copied_length)
				+ field_differs("truncated", want.truncated, result.truncated)
				+ field_differs("run_last", want.run_last, result.run_last);
			if (wrong != 0)
				bad_count++;
			if (want.result_kind == KIND_SUMMARY)
				n_summary++;
			else
				n_payload++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.local_addr      = '0;
			regs.wanted_protocol = '0;
			regs.copy_limit      = COPY_LIMIT_RESET;
			clear_packet();
			due_results.delete();
			bad_count = 0;
			n_payload = 0;
			n_summary = 0;
			due_left     <= 0;
			mismatches   <= 0;
			payload_seen <= 0;
			summary_seen <= 0;
		end else begin
			// results of a byte appear only after it is registered and checked, so compare before adding new ones
			if (result.valid === 1'b1 && result.ready === 1'b1)
				compare_result();
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
				write_register(cfg.index, cfg.data);
			if (frame.valid === 1'b1 && frame.ready === 1'b1)
				filter_byte(frame.frame_byte, frame.frame_last);
			due_left     <= due_results.size();
			mismatches   <= bad_count;
			payload_seen <= n_payload;
			summary_seen <= n_summary;
		end
	end

endmodule

### tb/sv/tb_ipv4_receive_filter.sv
`timescale 1ns / 1ps

module tb_ipv4_receive_filter;
	import ipvrf_pkg::*;

	typedef enum {FLAW_NONE, FLAW_VERSION, FLAW_CSUM, FLAW_PROTO, FLAW_DST} flaw_t;

	logic clk;
	logic arst_n;
	bit   calm;

	ipvrf_in_if  frame_ch();
	ipvrf_out_if result_ch();
	ipvrf_cfg_if cfg_ch();

	int unsigned due_left;
	int unsigned mismatches;
	int unsigned payload_seen;
	int unsigned summary_seen;

	logic [31:0]      cur_local;
	logic [7:0]       cur_proto;
	logic [7:0]       frame_q[$];
	int unsigned      frames_sent;
	int unsigned      bytes_driven;
	int unsigned      settings_used;

	ipv4_receive_filter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	ipvrf_monitor mon (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame        (frame_ch),
		.result       (result_ch),
		.cfg          (cfg_ch),
		.due_left     (due_left),
		.mismatches   (mismatches),
		.payload_seen (payload_seen),
		.summary_seen (summary_seen)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= calm || ($urandom_range(99) >= 34);
		end
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results still due", due_left);
		$display("FAIL ipv4_receive_filter");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(99) < 34) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid      <= 1'b1;
		frame_ch.frame_byte <= b;
		frame_ch.frame_last <= last;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
		frames_sent++;
		bytes_driven += frame_q.size();
	endtask

	// wait out every due result, then the pipeline of a frame that produced none
	task automatic settle();
		frame_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (due_left != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
	endtask

	task automatic load_setting(input logic [31:0] addr, input logic [7:0] proto,
		input logic [LEN_W-1:0] limit);
		write_reg(CFG_LOCAL_ADDR, addr);
		write_reg(CFG_WANTED_PROTOCOL, {24'd0, proto});
		write_reg(CFG_COPY_LIMIT, {21'd0, limit});
		cfg_ch.valid <= 1'b0;
		cur_local = addr;
		cur_proto = proto;
		settings_used++;
	endtask

	function automatic logic [15:0] header_sum(input int hdr);
		logic [16:0] s;
		s = '0;
		for (int i = 0; i < hdr; i += 2) begin
			s = {1'b0, s[15:0]} + {1'b0, frame_q[i], frame_q[i+1]};
			if (s[16])
				s = {1'b0, s[15:0]} + 17'd1;
		end
		return ~s[15:0];
	endfunction

	// header with random filler, body bytes after it; an ihl below five still gets 20 bytes
	task automatic build_packet(input int ihl, input logic [15:0] total, input int body,
		input flaw_t flaw);
		int          hdr;
		int          ver;
		logic [15:0] csum;
		hdr = (ihl < 5 ? 5 : ihl) * 4;
		ver = IP_VERSION;
		if (flaw == FLAW_VERSION) begin
			ver = $urandom_range(14);
			if (ver >= IP_VERSION)
				ver++;
		end
		frame_q.delete();
		for (int i = 0; i < hdr + body; i++)
			frame_q.push_back(8'($urandom_range(255)));
		frame_q[0]  = {4'(ver), 4'(ihl)};
		frame_q[OFS_TOTAL_HI] = total[15:8];
		frame_q[OFS_TOTAL_LO] = total[7:0];
		frame_q[OFS_PROTOCOL] = cur_proto;
		frame_q[10] = 8'h00;
		frame_q[11] = 8'h00;
		for (int i = 0; i < 4; i++)
			frame_q[OFS_DST + i] = cur_local[8 * (3 - i) +: 8];
		if (flaw == FLAW_PROTO)
			frame_q[OFS_PROTOCOL] = cur_proto ^ 8'($urandom_range(255, 1));
		if (flaw == FLAW_DST)
			frame_q[OFS_DST + $urandom_range(3)] ^= 8'($urandom_range(255, 1));
		csum = header_sum(hdr);
		if (flaw == FLAW_CSUM)
			csum ^= 16'($urandom_range(65535, 1));
		frame_q[10] = csum[15:8];
		frame_q[11] = csum[7:0];
	endtask

	task automatic trim_frame(input int keep);
		while (frame_q.size() > keep)
			void'(frame_q.pop_back());
	endtask

	task automatic noise_frame(input int len, input int fill);
		frame_q.delete();
		repeat (len)
			frame_q.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
	endtask

	task automatic random_frame();
		int    pick;
		int    ihl;
		int    hdr;
		int    pay;
		int    tail;
		flaw_t flaw;
		pick = $urandom_range(99);
		ihl  = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
		hdr  = ihl * 4;
		pay  = $urandom_range(40, 1);
		if (pick < 60) begin
			tail = $urandom_range(9);
			if (tail < 6)
				build_packet(ihl, 16'(hdr + pay), pay, FLAW_NONE);
			else if (tail < 8)
				build_packet(ihl, 16'(hdr + pay), pay + $urandom_range(12, 1), FLAW_NONE);
			else
				build_packet(ihl, ($urandom_range(4) == 0) ? 16'hFFFF :
					16'(hdr + pay + $urandom_range(60, 1)), $urandom_range(pay), FLAW_NONE);
		end else if (pick < 70) begin
			case ($urandom_range(4))
				0: flaw = FLAW_VERSION;
				1: flaw = FLAW_CSUM;
				2: flaw = FLAW_PROTO;
				3: flaw = FLAW_DST;
				default: flaw = FLAW_NONE;
			endcase
			if (flaw == FLAW_NONE)
				build_packet($urandom_range(4), 16'(20 + pay), pay, FLAW_NONE);
			else
				build_packet(ihl, 16'(hdr + pay), pay, flaw);
		end else if (pick < 78) begin
			build_packet(ihl, 16'($urandom_range(hdr)), $urandom_range(8), FLAW_NONE);
		end else if (pick < 88) begin
			build_packet(ihl, 16'(hdr + pay), pay, FLAW_NONE);
			trim_frame($urandom_range(hdr - 1, 1));
		end else begin
			noise_frame($urandom_range(30, 1), -1);
		end
	endtask

	task automatic random_phase(input int byte_goal);
		int unsigned start;
		start = bytes_driven;
		while (bytes_driven - start < byte_goal) begin
			random_frame();
			send_frame();
		end
	endtask

	initial begin
		frame_ch.valid      <= 1'b0;
		frame_ch.frame_byte <= 8'h00;
		frame_ch.frame_last <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= CFG_LOCAL_ADDR;
		cfg_ch.data         <= 32'd0;
		arst_n              <= 1'b0;
		calm          = 1'b0;
		cur_local     = 32'd0;
		cur_proto     = 8'd0;
		frames_sent   = 0;
		bytes_driven  = 0;
		settings_used = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed frames under the reset register values
		build_packet(5, 16'd21, 1, FLAW_NONE);           send_frame();
		build_packet(15, 16'd63, 3, FLAW_NONE);          send_frame();
		build_packet(5, 16'd20, 2, FLAW_NONE);           send_frame();
		build_packet(5, 16'd0, 0, FLAW_NONE);            send_frame();
		build_packet(5, 16'd24, 4, FLAW_VERSION);        send_frame();
		build_packet(4, 16'd24, 4, FLAW_NONE);           send_frame();
		build_packet(0, 16'd24, 4, FLAW_NONE);           send_frame();
		build_packet(5, 16'd24, 4, FLAW_CSUM);           send_frame();
		build_packet(5, 16'd24, 4, FLAW_PROTO);          send_frame();
		build_packet(5, 16'd24, 4, FLAW_DST);            send_frame();
		build_packet(5, 16'd24, 4, FLAW_NONE);
		trim_frame(19);                                  send_frame();
		noise_frame(1, 8'h45);                           send_frame();
		build_packet(5, 16'd25, 15, FLAW_NONE);          send_frame();
		build_packet(5, 16'hFFFF, 6, FLAW_NONE);         send_frame();
		build_packet(5, 16'd30, 0, FLAW_NONE);           send_frame();
		noise_frame(8, 8'hFF);                           send_frame();
		noise_frame(8, 8'h00);                           send_frame();
		settle();

		load_setting(32'hFFFF_FFFF, 8'hFF, 11'd2047);
		// position counter saturates: one frame runs past the limit, one pads far beyond
		build_packet(5, 16'hFFFF, 2029, FLAW_NONE);      send_frame();
		build_packet(5, 16'd600, 2080, FLAW_NONE);       send_frame();
		random_phase(190);
		settle();

		load_setting($urandom, 8'd6, 11'd0);
		random_phase(180);
		settle();

		load_setting($urandom, 8'd17, 11'd4);
		random_phase(190);
		settle();

		calm = 1'b1;
		load_setting(32'd0, 8'd0, 11'd1);
		random_phase(180);
		settle();
		calm = 1'b0;

		load_setting($urandom, 8'($urandom_range(255)), 11'($urandom_range(60, 5)));
		random_phase(180);
		settle();

		load_setting($urandom, 8'($urandom_range(255)), COPY_LIMIT_RESET);
		random_phase(180);
		settle();

		$display("covered %0d frames, %0d input bytes, %0d register settings",
			frames_sent, bytes_driven, settings_used);
		$display("checked %0d payload bytes and %0d packet summaries",
			payload_seen, summary_seen);
		if (mismatches == 0 && due_left == 0)
			$display("PASS ipv4_receive_filter");
		else
			$display("FAIL ipv4_receive_filter");
		$finish;
	end

endmodule
